### rtl/pacl_pkg.sv
// ----------------------------------------------------------------------------
// pacl_pkg
// Shared types, field widths and codes for the prefix bind-check block.
// ----------------------------------------------------------------------------
package pacl_pkg;

    // Table size default handed to the top level.
    localparam int TableEntriesDef = 16;

    // Field widths of one transaction.
    localparam int IdxW   = 4;
    localparam int AddrW  = 64;
    localparam int PlenW  = 8;
    localparam int EtypeW = 2;
    localparam int QtypeW = 3;

    // Packed slave tdata width, padded to whole bytes.
    localparam int SDataRawW = IdxW + 1 + 1 + AddrW + AddrW + PlenW + 1 + EtypeW + QtypeW;
    localparam int SDataW    = ((SDataRawW + 7) / 8) * 8;
    localparam int MDataW    = 8;

    // Bit offsets inside the slave tdata.
    localparam int OffIdx   = 0;
    localparam int OffValid = OffIdx + IdxW;
    localparam int OffFam   = OffValid + 1;
    localparam int OffHigh  = OffFam + 1;
    localparam int OffLow   = OffHigh + AddrW;
    localparam int OffPlen  = OffLow + AddrW;
    localparam int OffNever = OffPlen + PlenW;
    localparam int OffEtype = OffNever + 1;
    localparam int OffQtype = OffEtype + EtypeW;

    // Command codes carried in tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Address families.
    localparam logic FAM_IPV4 = 1'b0;
    localparam logic FAM_IPV6 = 1'b1;

    // Query socket type codes; any code from QT_ERROR up is an error.
    localparam logic [QtypeW-1:0] QT_NONE  = 3'd0;
    localparam logic [QtypeW-1:0] QT_TCP   = 3'd1;
    localparam logic [QtypeW-1:0] QT_UDP   = 3'd2;
    localparam logic [QtypeW-1:0] QT_OTHER = 3'd3;
    localparam logic [QtypeW-1:0] QT_ERROR = 3'd4;

    // Entry socket type codes; the last one allows no known type.
    localparam logic [EtypeW-1:0] ET_ANY      = 2'd0;
    localparam logic [EtypeW-1:0] ET_TCP      = 2'd1;
    localparam logic [EtypeW-1:0] ET_UDP      = 2'd2;
    localparam logic [EtypeW-1:0] ET_RESERVED = 2'd3;

    // Prefix length limits per family.
    localparam logic [PlenW-1:0] PLEN_V4_MAX = 8'd32;
    localparam logic [PlenW-1:0] PLEN_V6_MAX = 8'd128;

    // One stored rule.
    typedef struct packed {
        logic              family;
        logic [AddrW-1:0]  addr_high;
        logic [AddrW-1:0]  addr_low;
        logic [PlenW-1:0]  prefix_len;
        logic              never_bind;
        logic [EtypeW-1:0] sock_type;
    } t_rule;

    // Query held during a table scan.
    typedef struct packed {
        logic              family;
        logic [AddrW-1:0]  addr_high;
        logic [AddrW-1:0]  addr_low;
        logic [QtypeW-1:0] sock_type;
    } t_query;

endpackage

### rtl/pacl_rule_mem.sv
// ----------------------------------------------------------------------------
// pacl_rule_mem
// Rule table: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
module pacl_rule_mem #(
    parameter int ENTRIES = pacl_pkg::TableEntriesDef,
    parameter int IW      = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_idx,
    input  logic            i_wr_valid,
    input  pacl_pkg::t_rule i_wr_rule,
    input  logic [IW-1:0]   i_rd_idx,
    output logic            o_rd_valid,
    output pacl_pkg::t_rule o_rd_rule
);

    pacl_pkg::t_rule r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic            r_rd_valid;
    pacl_pkg::t_rule r_rd_rule;

    // Valid bits are cleared by reset; the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= i_wr_valid;
        end
    end

    // Payload write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_rule;
        end
    end

    // Registered read of one entry per cycle.
    always_ff @(posedge i_clk) begin
        r_rd_rule  <= r_mem[i_rd_idx];
        r_rd_valid <= r_valid[i_rd_idx];
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_rule  = r_rd_rule;

endmodule

### rtl/pacl_match.sv
// ----------------------------------------------------------------------------
// pacl_match
// Shared compare unit: decides whether one rule refuses the held query.
// ----------------------------------------------------------------------------
module pacl_match (
    input  pacl_pkg::t_rule  i_rule,
    input  pacl_pkg::t_query i_query,
    output logic             o_refuse
);

    logic [pacl_pkg::PlenW-1:0] v4_len;
    logic [pacl_pkg::PlenW-1:0] v6_len;
    logic [31:0]                v4_mask;
    logic [127:0]               v6_mask;
    logic                       v4_hit;
    logic                       v6_hit;
    logic                       pfx_hit;
    logic                       type_refuse;
    logic                       rule_refuse;

    // Clamp the prefix length to the family's address width.
    always_comb begin
        v4_len = (i_rule.prefix_len > pacl_pkg::PLEN_V4_MAX) ?
                 pacl_pkg::PLEN_V4_MAX : i_rule.prefix_len;
        v6_len = (i_rule.prefix_len > pacl_pkg::PLEN_V6_MAX) ?
                 pacl_pkg::PLEN_V6_MAX : i_rule.prefix_len;
    end

    // Leading-bit masks; a zero length compares nothing.
    always_comb begin
        if (v4_len == '0) begin
            v4_mask = '0;
        end else begin
            v4_mask = {32{1'b1}} << (6'd32 - v4_len[5:0]);
        end
        if (v6_len == '0) begin
            v6_mask = '0;
        end else begin
            v6_mask = {128{1'b1}} << (8'd128 - v6_len);
        end
    end

    // Prefix compare; IPv4 looks at the low 32 bits only.
    always_comb begin
        v4_hit = ((i_query.addr_low[31:0] ^ i_rule.addr_low[31:0]) & v4_mask) == '0;
        v6_hit = (({i_query.addr_high, i_query.addr_low} ^
                   {i_rule.addr_high, i_rule.addr_low}) & v6_mask) == '0;
        pfx_hit = (i_query.family == pacl_pkg::FAM_IPV4) ? v4_hit : v6_hit;
    end

    // Socket-type restriction and never-bind mark.
    always_comb begin
        type_refuse = (i_query.sock_type != pacl_pkg::QT_NONE) &&
                      (i_rule.sock_type != pacl_pkg::ET_ANY) &&
                      ((i_query.sock_type == pacl_pkg::QT_OTHER) ||
                       ({1'b0, i_rule.sock_type} != i_query.sock_type));
        rule_refuse = i_rule.never_bind || type_refuse;
        o_refuse    = rule_refuse && pfx_hit && (i_rule.family == i_query.family);
    end

endmodule

### rtl/prefix_acl_bind_check.sv
// Timing: a table write is registered; a query is scanned in ST_SCAN, then
// ST_DONE registers its verdict; a socket-type error goes straight to ST_DONE.
// Scan: the single rule-table read port and compare unit visit one entry per cycle,
// and no new transaction is taken until the previous verdict is registered;
// a verdict still held on the output stalls the next query in its last state.
// Reset: synchronous, active low; clears all valid bits and the sequencer.
// ----------------------------------------------------------------------------
// prefix_acl_bind_check
// Prefix rule table with a sequential scan deciding whether an address binds.
// ----------------------------------------------------------------------------
module prefix_acl_bind_check #(
    parameter int TABLE_ENTRIES = pacl_pkg::TableEntriesDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tdata from bit 0: entry_index, entry_valid, family, addr_high, addr_low,
    // prefix_length, never_bind, entry_sock_type, query_sock_type, zero pad
    input  logic [pacl_pkg::SDataW-1:0] i_s_axis_tdata,
    // tuser: command
    input  logic                        i_s_axis_tuser,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata from bit 0: bindable, zero pad
    output logic [pacl_pkg::MDataW-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_cmp_valid, n_cmp_valid;
    logic             r_ok, n_ok;
    logic             r_out_valid, n_out_valid;
    logic             r_out_bind, n_out_bind;
    pacl_pkg::t_query r_query, n_query;

    logic             s_accept;
    logic             wr_en;
    logic             wr_valid;
    logic [pacl_pkg::IdxW-1:0] wr_idx_raw;
    pacl_pkg::t_rule  in_rule;
    pacl_pkg::t_query in_query;
    logic             rd_valid;
    pacl_pkg::t_rule  rd_rule;
    logic             refuse;

    // Unpack the slave transaction.
    always_comb begin
        wr_idx_raw          = i_s_axis_tdata[pacl_pkg::OffIdx +: pacl_pkg::IdxW];
        wr_valid            = i_s_axis_tdata[pacl_pkg::OffValid];
        in_rule.family      = i_s_axis_tdata[pacl_pkg::OffFam];
        in_rule.addr_high   = i_s_axis_tdata[pacl_pkg::OffHigh +: pacl_pkg::AddrW];
        in_rule.addr_low    = i_s_axis_tdata[pacl_pkg::OffLow +: pacl_pkg::AddrW];
        in_rule.prefix_len  = i_s_axis_tdata[pacl_pkg::OffPlen +: pacl_pkg::PlenW];
        in_rule.never_bind  = i_s_axis_tdata[pacl_pkg::OffNever];
        in_rule.sock_type   = i_s_axis_tdata[pacl_pkg::OffEtype +: pacl_pkg::EtypeW];
        in_query.family     = in_rule.family;
        in_query.addr_high  = in_rule.addr_high;
        in_query.addr_low   = in_rule.addr_low;
        in_query.sock_type  = i_s_axis_tdata[pacl_pkg::OffQtype +: pacl_pkg::QtypeW];
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Writes beyond the table are dropped.
    assign wr_en = s_accept && (i_s_axis_tuser == pacl_pkg::CMD_WRITE) &&
                   (32'(wr_idx_raw) < TABLE_ENTRIES);

    pacl_rule_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (IW'(wr_idx_raw)),
        .i_wr_valid (wr_valid),
        .i_wr_rule  (in_rule),
        .i_rd_idx   (r_cnt[IW-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_rule  (rd_rule)
    );

    pacl_match u_match (
        .i_rule   (rd_rule),
        .i_query  (r_query),
        .o_refuse (refuse)
    );

    // Sequencer: issue one table read per cycle, compare it in the cycle after.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmp_valid = 1'b0;
        n_ok        = r_ok;
        n_query     = r_query;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_bind  = r_out_bind;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && (i_s_axis_tuser == pacl_pkg::CMD_QUERY)) begin
                    n_query = in_query;
                    n_cnt   = '0;
                    if (in_query.sock_type >= pacl_pkg::QT_ERROR) begin
                        n_ok    = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cmp_valid && rd_valid && refuse) begin
                    n_ok = 1'b0;
                end
                if (r_cnt != CNT_END) begin
                    n_cnt       = r_cnt + 1'b1;
                    n_cmp_valid = 1'b1;
                end else if (!r_cmp_valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bind  = r_ok;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ok       <= n_ok;
        r_query    <= n_query;
        r_out_bind <= n_out_bind;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(pacl_pkg::MDataW - 1){1'b0}}, r_out_bind};

endmodule
